@@ hdl/stcaf_pkg.sv @@
// ----------------------------------------------------------------------------
// stcaf_pkg
// Shared types and constants of the signed tenths to ASCII formatter.
// ----------------------------------------------------------------------------
package stcaf_pkg;

  localparam int unsigned InWidth   = 15;
  localparam int unsigned MagWidth  = 14;
  localparam int unsigned CharWidth = 8;
  localparam int unsigned NumChars  = 6;

  localparam logic [MagWidth-1:0]  MaxMag    = 14'd9999;
  localparam logic [CharWidth-1:0] CharSpace = 8'h20;
  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharPlus  = 8'h2B;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2D;
  localparam logic [CharWidth-1:0] CharPoint = 8'h2E;

  // Decimal digits of one reading, as handed to the serializer.
  typedef struct packed {
    logic       neg;
    logic [3:0] hun;
    logic [3:0] ten;
    logic [3:0] one;
    logic [3:0] tenths;
  } digits_t;

endpackage

@@ hdl/stcaf_digit_pipe.sv @@
// ----------------------------------------------------------------------------
// stcaf_digit_pipe
// Four-stage pipeline: magnitude and saturation, divide by ten, divide by one
// hundred, split the remainder into tens and ones.
// ----------------------------------------------------------------------------
module stcaf_digit_pipe (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [stcaf_pkg::InWidth-1:0] value_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output stcaf_pkg::digits_t                  digits_o
);
  import stcaf_pkg::*;

  logic en_a, en_b, en_c, en_d;
  logic va_q, vb_q, vc_q, vd_q;

  // Stage A: sign and saturated magnitude.
  logic                neg_a_q;
  logic [MagWidth-1:0] mag_a_q;
  logic [InWidth-1:0]  abs_d;
  logic [MagWidth-1:0] mag_a_d;

  // Stage B: whole part and tenths.
  logic       neg_b_q;
  logic [9:0] whole_b_q;
  logic [3:0] tenths_b_q;
  logic [26:0] prod_b;
  logic [9:0]  whole_b_d;
  logic [MagWidth-1:0] rem_b;

  // Stage C: hundreds and remainder below one hundred.
  logic       neg_c_q;
  logic [3:0] hun_c_q;
  logic [6:0] rem_c_q;
  logic [3:0] tenths_c_q;
  logic [15:0] prod_c;
  logic [3:0]  hun_c_d;
  logic [9:0]  rem_c_full;

  // Stage D: final digits.
  digits_t    dig_d_q;
  logic [14:0] prod_d;
  logic [3:0]  ten_d_d;
  logic [6:0]  one_full;

  assign en_d    = !vd_q || ready_i;
  assign en_c    = !vc_q || en_d;
  assign en_b    = !vb_q || en_c;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;

  always_comb begin
    abs_d = value_i[InWidth-1] ? (~value_i + 15'd1) : value_i;
    if (abs_d > {1'b0, MaxMag}) begin
      mag_a_d = MaxMag;
    end else begin
      mag_a_d = abs_d[MagWidth-1:0];
    end
  end

  // x / 10 as (x * 6554) >> 16, exact for x below 10000.
  assign prod_b    = 27'(mag_a_q) * 27'd6554;
  assign whole_b_d = prod_b[25:16];
  assign rem_b     = mag_a_q - ({4'd0, whole_b_d} << 3) - ({4'd0, whole_b_d} << 1);

  // x / 100 as (x * 41) >> 12, exact for x below 1000.
  assign prod_c     = 16'(whole_b_q) * 16'd41;
  assign hun_c_d    = prod_c[15:12];
  assign rem_c_full = whole_b_q - (10'(hun_c_d) * 10'd100);

  // x / 10 as (x * 205) >> 11, exact for x below 100.
  assign prod_d   = 15'(rem_c_q) * 15'd205;
  assign ten_d_d  = prod_d[14:11];
  assign one_full = rem_c_q - ({3'd0, ten_d_d} << 3) - ({3'd0, ten_d_d} << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (en_a) va_q <= valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
      if (en_d) vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      neg_a_q <= value_i[InWidth-1];
      mag_a_q <= mag_a_d;
    end
    if (en_b) begin
      neg_b_q    <= neg_a_q;
      whole_b_q  <= whole_b_d;
      tenths_b_q <= rem_b[3:0];
    end
    if (en_c) begin
      neg_c_q    <= neg_b_q;
      hun_c_q    <= hun_c_d;
      rem_c_q    <= rem_c_full[6:0];
      tenths_c_q <= tenths_b_q;
    end
    if (en_d) begin
      dig_d_q.neg    <= neg_c_q;
      dig_d_q.hun    <= hun_c_q;
      dig_d_q.ten    <= ten_d_d;
      dig_d_q.one    <= one_full[3:0];
      dig_d_q.tenths <= tenths_c_q;
    end
  end

  assign valid_o  = vd_q;
  assign digits_o = dig_d_q;

endmodule

@@ hdl/stcaf_char_ser.sv @@
// ----------------------------------------------------------------------------
// stcaf_char_ser
// Builds the six characters of one reading and shifts them out, one per beat.
// ----------------------------------------------------------------------------
module stcaf_char_ser (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  stcaf_pkg::digits_t                    digits_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [stcaf_pkg::CharWidth-1:0]       char_out_o,
  output logic                                  last_char_o
);
  import stcaf_pkg::*;

  localparam int unsigned BufWidth = NumChars * CharWidth;

  logic                valid_q;
  logic [2:0]          cnt_q;
  logic [BufWidth-1:0] buf_q;
  logic                last;
  logic                beat;
  logic                show_h, show_t, show_o;
  logic [BufWidth-1:0] load_d;

  assign last    = (cnt_q == 3'(NumChars - 1));
  assign beat    = valid_q && !out_stall_i;
  assign ready_o = !valid_q || (beat && last);

  always_comb begin
    show_h = (digits_i.hun != 4'd0);
    show_t = show_h || (digits_i.ten != 4'd0);
    show_o = show_t || (digits_i.one != 4'd0);
    load_d = {digits_i.neg ? CharMinus : CharPlus,
              show_h ? (CharZero | {4'd0, digits_i.hun}) : CharSpace,
              show_t ? (CharZero | {4'd0, digits_i.ten}) : CharSpace,
              show_o ? (CharZero | {4'd0, digits_i.one}) : CharSpace,
              CharPoint,
              CharZero | {4'd0, digits_i.tenths}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 3'd0;
    end else if (ready_o) begin
      valid_q <= valid_i;
      cnt_q   <= 3'd0;
    end else if (beat) begin
      cnt_q <= cnt_q + 3'd1;
    end
  end

  // Load a fresh reading, or advance one character per beat.
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      buf_q <= load_d;
    end else if (beat) begin
      buf_q <= {buf_q[BufWidth-CharWidth-1:0], CharSpace};
    end
  end

  assign out_valid_o = valid_q;
  assign char_out_o  = buf_q[BufWidth-1 -: CharWidth];
  assign last_char_o = last;

endmodule

@@ hdl/signed_tenths_to_ascii_formatter.sv @@
// ----------------------------------------------------------------------------
// signed_tenths_to_ascii_formatter
// Turns a signed reading in tenths into six ASCII characters: sign, three
// integer digits with leading spaces, decimal point and tenths digit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with value_tenths_i, a signed
//   reading in units of 0.1. Magnitudes above 999.9 saturate to 999.9.
//   Output channel: out_valid_o / out_stall_i with char_out_o and
//   last_char_o; each reading gives six beats, the sixth flagged last.
//   A reading passes the four pipeline stages and then the character register
//   before its first character is valid. The reading rate is set by the
//   character serializer, which sends one character per cycle while
//   out_stall_i is low. Up to four readings wait in the pipeline while the
//   serializer is busy, so a new reading can be taken every cycle until it
//   fills.
//   Reset clears all valid bits; no characters are pending after reset.
//   While out_stall_i is high the current character holds, the pipeline
//   stops once full and in_stall_o rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module signed_tenths_to_ascii_formatter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [stcaf_pkg::InWidth-1:0]  value_tenths_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [stcaf_pkg::CharWidth-1:0]       char_out_o,
  output logic                                  last_char_o
);
  import stcaf_pkg::*;

  logic    pipe_ready;
  logic    dig_valid;
  logic    ser_ready;
  digits_t digits;

  stcaf_digit_pipe u_digit_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (pipe_ready),
    .value_i  (value_tenths_i),
    .valid_o  (dig_valid),
    .ready_i  (ser_ready),
    .digits_o (digits)
  );

  stcaf_char_ser u_char_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (dig_valid),
    .ready_o     (ser_ready),
    .digits_i    (digits),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_out_o  (char_out_o),
    .last_char_o (last_char_o)
  );

  assign in_stall_o = !pipe_ready;

endmodule
